FILE: hw/rtl/pt_pkg.sv
// Package for the pid trust table: geometry constants, action and trust codes,
// and the way, row, request and result types.
// No dependencies; pt_way_match and pid_trust_table import it.
`timescale 1ns / 1ps

package pt_pkg;

    // Table geometry; the bucket count is a power of two so the bucket is the low pid bits
    localparam int BUCKET_COUNT    = 256;
    localparam int WAYS_PER_BUCKET = 4;
    localparam int BUCKET_BITS     = $clog2(BUCKET_COUNT);
    localparam int KEY_W           = 32;
    localparam int TRUST_W         = 2;

    // Item actions
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    // Trust codes
    localparam logic [TRUST_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [TRUST_W-1:0] ST_ALLOWED = 2'd1;
    localparam logic [TRUST_W-1:0] ST_DENIED  = 2'd2;

    // One way of a bucket row
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TRUST_W-1:0] trust;
    } t_way;

    typedef t_way [WAYS_PER_BUCKET-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // Held request of the item in flight
    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   pid;
        logic [TRUST_W-1:0] new_state;
    } t_req;

    // Result item, packed lowest field last: found sits in bit 0
    typedef struct packed {
        logic               bucket_full;
        logic               trusted;
        logic [TRUST_W-1:0] stored_state;
        logic               found;
    } t_result;

endpackage

FILE: hw/rtl/pt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pt_way_match.sv
// Bucket row update: compares all ways against the pid, picks the hit or the
// first free way, and builds the write-back row and the result item.
// Depends on pt_pkg.
`timescale 1ns / 1ps

module pt_way_match (
    input  pt_pkg::t_row    i_row,
    input  pt_pkg::t_req    i_req,
    input  logic            i_enf,
    output pt_pkg::t_row    o_row,
    output pt_pkg::t_result o_res
);

    import pt_pkg::*;

    logic [WAYS_PER_BUCKET-1:0] hit_raw;
    logic [WAYS_PER_BUCKET-1:0] hit_sel;
    logic [WAYS_PER_BUCKET-1:0] free_sel;
    logic                       any_hit;
    logic                       any_free;
    logic                       seen_free;
    logic [TRUST_W-1:0]         ns_sat;
    logic [TRUST_W-1:0]         set_st;
    logic [TRUST_W-1:0]         hit_trust;

    // Per-way compare, then first-hit and first-free priority picks
    always_comb begin
        any_hit   = 1'b0;
        seen_free = 1'b0;
        hit_trust = ST_UNKNOWN;
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            hit_raw[w]  = i_row[w].valid && (i_row[w].key == i_req.pid);
            hit_sel[w]  = hit_raw[w] && !any_hit;
            free_sel[w] = !i_row[w].valid && !seen_free;
            if (hit_sel[w]) begin
                hit_trust = i_row[w].trust;
            end
            any_hit   = any_hit || hit_raw[w];
            seen_free = seen_free || !i_row[w].valid;
        end
        any_free = seen_free;
    end

    // Code three has no meaning and saturates to denied
    assign ns_sat = (i_req.new_state > ST_DENIED) ? ST_DENIED : i_req.new_state;
    assign set_st = (i_req.action == ACT_ADD) ? ST_UNKNOWN : ns_sat;

    // Row write-back and result
    always_comb begin
        o_row = i_row;
        o_res = '0;
        o_res.found = any_hit;
        unique case (i_req.action) inside
            ACT_ADD, ACT_SET: begin
                if (any_hit) begin
                    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
                        if (hit_sel[w]) begin
                            o_row[w].trust = set_st;
                        end
                    end
                    o_res.stored_state = set_st;
                end else if (any_free) begin
                    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
                        if (free_sel[w]) begin
                            o_row[w].valid = 1'b1;
                            o_row[w].key   = i_req.pid;
                            o_row[w].trust = set_st;
                        end
                    end
                    o_res.stored_state = set_st;
                end else begin
                    o_res.bucket_full = 1'b1;
                end
            end
            ACT_REMOVE: begin
                for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
                    if (hit_sel[w]) begin
                        o_row[w].valid = 1'b0;
                    end
                end
            end
            ACT_QUERY: begin
                o_res.stored_state = any_hit ? hit_trust : ST_UNKNOWN;
                o_res.trusted      = !i_enf || (any_hit && hit_trust == ST_ALLOWED);
            end
            default: begin
                o_row = i_row;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pid_trust_table.sv
// An accepted item's bucket row is read into the RAM's read register; the row is
// then updated and written back, and the result loaded into the output register,
// once that register is free. No new item is taken until this write-back is done.
// Reset: synchronous; afterwards a clearing pass writes empty rows to all
// BUCKET_COUNT rows with s_axis_tready low; APB writes still work.
// Enforcement resets to off.
`timescale 1ns / 1ps

module pid_trust_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] pid, [33:32] new_state, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] found, [2:1] stored_state, [3] trusted,
                                       // [4] bucket_full, rest zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state                 r_state;
    logic [BUCKET_BITS-1:0] r_clr_cnt;
    logic                   r_enf;
    t_req                   r_req;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_accept;
    logic                   out_free;
    logic                   commit;
    logic                   cfg_wr;
    logic                   ram_we;
    logic [BUCKET_BITS-1:0] ram_waddr;
    t_row                   ram_wdata;
    t_row                   ram_rdata;
    t_row                   upd_row;
    t_result                upd_res;

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign commit        = (r_state == S_LOOKUP) && out_free;

    // APB register: enforcement flag at word 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_enf};

    // Table write port: clearing pass or row write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else begin
            ram_we    = commit;
            ram_waddr = r_req.pid[BUCKET_BITS-1:0];
            ram_wdata = upd_row;
        end
    end

    pt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKET_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (s_axis_tdata[BUCKET_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    pt_way_match u_match (
        .i_row (ram_rdata),
        .i_req (r_req),
        .i_enf (r_enf),
        .o_row (upd_row),
        .o_res (upd_res)
    );

    // Control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_enf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_enf <= pwdata[0];
            end
            // A new result wins over the drain of the old one
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == BUCKET_BITS'(BUCKET_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_req.action    <= t_action'(s_axis_tuser);
                        r_req.pid       <= s_axis_tdata[KEY_W-1:0];
                        r_req.new_state <= s_axis_tdata[KEY_W+TRUST_W-1:KEY_W];
                        r_state         <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    // Hold the read row until the output register can take the result
                    if (commit) begin
                        r_out   <= upd_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out};

`ifndef SYNTHESIS
    // An accepted item always moves on to its lookup
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOKUP))
        else $error("accepted item did not enter lookup");

    // A stalled result keeps the pending item parked in lookup
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP && r_out_valid && !m_axis_tready) |=> (r_state == S_LOOKUP))
        else $error("result register overwritten while stalled");

    // No item is taken while the table is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

    // A dropped insert never reports a present entry
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.bucket_full && (r_out.found || r_out.stored_state != '0)))
        else $error("bucket_full result carries entry data");
`endif

endmodule
